// ----- rtl/sfas_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_pkg
// Shared types and constants of the secp256k1 field add/sub unit.
// ----------------------------------------------------------------------------
package sfas_pkg;

	localparam int LIMB_W = 64;
	localparam int WORD_W = 256;

	// p = 2^256 - 2^32 - 977
	localparam logic [WORD_W-1:0] PRIME =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
	// 2^256 - p
	localparam logic [WORD_W-1:0] PRIME_COMPL = 256'h1_000003D1;

	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_SUB    = 3'd1,
		ACT_NEG    = 3'd2,
		ACT_HALF   = 3'd3,
		ACT_REDUCE = 3'd4,
		ACT_RANGE  = 3'd5
	} action_t;

	typedef struct packed {
		logic [WORD_W-1:0] r;
		logic              a_below_prime;
		logic              operands_equal;
		logic              result_zero;
		logic              result_odd;
	} result_t;

endpackage

// ----- rtl/secp256k1_field_add_sub_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secp256k1_field_add_sub_unit
// Modular add/sub unit over the secp256k1 prime field.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on each rising edge with start high and busy low.
//   busy is always low, so a new request may be issued every cycle.
//   The request carries an action code and operands a and b as four 64-bit
//   limbs each, least significant limb first.
//   Each request yields one result: r_limb0..r_limb3 plus the flags
//   a_below_prime, operands_equal, result_zero and result_odd, shown for one
//   cycle with done high.
//   A request passes from the input register through one pass of 256-bit
//   adders into the result register, which drives done. Throughput: one
//   request per cycle, as neither register waits on the other.
//   Reset clears the valid bits of both stages; no request is in flight after
//   reset. The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module secp256k1_field_add_sub_unit
	import sfas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        action,
	input  logic [LIMB_W-1:0] a_limb0,
	input  logic [LIMB_W-1:0] a_limb1,
	input  logic [LIMB_W-1:0] a_limb2,
	input  logic [LIMB_W-1:0] a_limb3,
	input  logic [LIMB_W-1:0] b_limb0,
	input  logic [LIMB_W-1:0] b_limb1,
	input  logic [LIMB_W-1:0] b_limb2,
	input  logic [LIMB_W-1:0] b_limb3,
	output logic              done,
	output logic [LIMB_W-1:0] r_limb0,
	output logic [LIMB_W-1:0] r_limb1,
	output logic [LIMB_W-1:0] r_limb2,
	output logic [LIMB_W-1:0] r_limb3,
	output logic              a_below_prime,
	output logic              operands_equal,
	output logic              result_zero,
	output logic              result_odd
);

	logic              valid_s1;
	logic [2:0]        action_s1;
	logic [WORD_W-1:0] a_s1;
	logic [WORD_W-1:0] b_s1;
	result_t           res;
	logic              valid_s2;
	result_t           res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= action;
			a_s1      <= {a_limb3, a_limb2, a_limb1, a_limb0};
			b_s1      <= {b_limb3, b_limb2, b_limb1, b_limb0};
		end
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	sfas_datapath u_datapath (
		.action (action_s1),
		.a      (a_s1),
		.b      (b_s1),
		.res    (res)
	);

	assign done           = valid_s2;
	assign r_limb0        = res_s2.r[LIMB_W-1:0];
	assign r_limb1        = res_s2.r[2*LIMB_W-1:LIMB_W];
	assign r_limb2        = res_s2.r[3*LIMB_W-1:2*LIMB_W];
	assign r_limb3        = res_s2.r[4*LIMB_W-1:3*LIMB_W];
	assign a_below_prime  = res_s2.a_below_prime;
	assign operands_equal = res_s2.operands_equal;
	assign result_zero    = res_s2.result_zero;
	assign result_odd     = res_s2.result_odd;

	a_req_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("request did not produce a result two cycles later");

	a_no_req_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result produced without a request");

	a_sub_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && action_s1 == ACT_SUB && a_s1 == b_s1 |=> done && result_zero)
		else $error("subtracting equal operands did not give zero");

	a_range_passes_a: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && action_s1 == ACT_RANGE |=>
		res_s2.r == $past(a_s1) && a_below_prime == ($past(a_s1) < PRIME))
		else $error("range check result differs from operand a");

endmodule

// ----- rtl/sfas_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfas_datapath
// Single-pass modular add, sub, neg, half, reduce and range check with flags.
// ----------------------------------------------------------------------------
module sfas_datapath
	import sfas_pkg::*;
(
	input  logic [2:0]        action,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output result_t           res
);

	logic              is_neg;
	logic [WORD_W-1:0] sub_x;
	logic [WORD_W-1:0] sub_y;
	logic [WORD_W:0]   sum_ab;
	logic [WORD_W+1:0] sum_abk;
	logic [WORD_W:0]   diff_xy;
	logic [WORD_W-1:0] diff_xyp;
	logic [WORD_W:0]   sum_ap;
	logic [WORD_W:0]   sum_ak;
	logic [WORD_W-1:0] add_r;
	logic [WORD_W-1:0] sub_r;
	logic [WORD_W-1:0] half_r;
	logic [WORD_W-1:0] red_r;
	logic [WORD_W-1:0] r;

	assign is_neg = (action == ACT_NEG);
	assign sub_x  = is_neg ? '0 : a;
	assign sub_y  = is_neg ? a : b;

	assign sum_ab   = {1'b0, a} + {1'b0, b};
	assign sum_abk  = {2'b00, a} + {2'b00, b} + {2'b00, PRIME_COMPL};
	assign diff_xy  = {1'b0, sub_x} - {1'b0, sub_y};
	assign diff_xyp = sub_x - sub_y - PRIME_COMPL;
	assign sum_ap   = {1'b0, a} + {1'b0, PRIME};
	assign sum_ak   = {1'b0, a} + {1'b0, PRIME_COMPL};

	// sum at or above p: take sum minus p
	assign add_r  = (sum_abk[WORD_W+1:WORD_W] != 2'b00) ? sum_abk[WORD_W-1:0]
		: sum_ab[WORD_W-1:0];
	// borrow: add p back
	assign sub_r  = diff_xy[WORD_W] ? diff_xyp : diff_xy[WORD_W-1:0];
	assign half_r = a[0] ? sum_ap[WORD_W:1] : {1'b0, a[WORD_W-1:1]};
	assign red_r  = sum_ak[WORD_W] ? sum_ak[WORD_W-1:0] : a;

	always_comb begin
		case (action)
			ACT_ADD:    r = add_r;
			ACT_SUB:    r = sub_r;
			ACT_NEG:    r = sub_r;
			ACT_HALF:   r = half_r;
			ACT_REDUCE: r = red_r;
			default:    r = a;
		endcase
	end

	assign res.r              = r;
	assign res.a_below_prime  = ~sum_ak[WORD_W];
	assign res.operands_equal = (a == b);
	assign res.result_zero    = (r == '0);
	assign res.result_odd     = r[0];

endmodule

// ----- bench/secp256k1_field_add_sub_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secp256k1_field_add_sub_checker
// Watches the request and result ports of the field add/sub unit. It computes
// the expected result and flags of each accepted request and compares every
// result, limb by limb and flag by flag, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module secp256k1_field_add_sub_checker
	import sfas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [2:0]        action,
	input  logic [LIMB_W-1:0] a_limb0,
	input  logic [LIMB_W-1:0] a_limb1,
	input  logic [LIMB_W-1:0] a_limb2,
	input  logic [LIMB_W-1:0] a_limb3,
	input  logic [LIMB_W-1:0] b_limb0,
	input  logic [LIMB_W-1:0] b_limb1,
	input  logic [LIMB_W-1:0] b_limb2,
	input  logic [LIMB_W-1:0] b_limb3,
	input  logic              done,
	input  logic [LIMB_W-1:0] r_limb0,
	input  logic [LIMB_W-1:0] r_limb1,
	input  logic [LIMB_W-1:0] r_limb2,
	input  logic [LIMB_W-1:0] r_limb3,
	input  logic              a_below_prime,
	input  logic              operands_equal,
	input  logic              result_zero,
	input  logic              result_odd,
	output int                fail_count,
	output int                pending,
	output int                results_checked
);

	result_t expected_results[$];

	function automatic result_t field_op_result(input logic [2:0] act,
			input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		logic [WORD_W:0]   wide;
		logic [WORD_W-1:0] r;
		result_t           res;
		case (act)
			ACT_ADD: begin
				wide = {1'b0, a} + {1'b0, b};
				if (wide[WORD_W] || wide[WORD_W-1:0] >= PRIME)
					r = wide[WORD_W-1:0] - PRIME;
				else
					r = wide[WORD_W-1:0];
			end
			ACT_SUB: begin
				r = a - b;
				if (a < b)
					r = r + PRIME;
			end
			ACT_NEG: begin
				r = '0 - a;
				if (a != '0)
					r = r + PRIME;
			end
			ACT_HALF: begin
				if (a[0])
					wide = {1'b0, a} + {1'b0, PRIME};
				else
					wide = {1'b0, a};
				r = wide[WORD_W:1];
			end
			ACT_REDUCE: begin
				r = (a >= PRIME) ? a - PRIME : a;
			end
			default: begin
				r = a;
			end
		endcase
		res.r              = r;
		res.a_below_prime  = (a < PRIME);
		res.operands_equal = (a == b);
		res.result_zero    = (r == '0);
		res.result_odd     = r[0];
		return res;
	endfunction

	function automatic int field_differs(input string field, input logic [LIMB_W-1:0] want,
			input logic [LIMB_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	initial begin
		fail_count      = 0;
		pending         = 0;
		results_checked = 0;
	end

	always @(posedge clk) begin
		result_t want;
		int      errs;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result with no request waiting: expected none, actual %h",
						$time, {r_limb3, r_limb2, r_limb1, r_limb0});
					fail_count = fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					errs = field_differs("r_limb0", want.r[63:0], r_limb0)
						+ field_differs("r_limb1", want.r[127:64], r_limb1)
						+ field_differs("r_limb2", want.r[191:128], r_limb2)
						+ field_differs("r_limb3", want.r[255:192], r_limb3)
						+ field_differs("a_below_prime", 64'(want.a_below_prime), 64'(a_below_prime))
						+ field_differs("operands_equal", 64'(want.operands_equal),
							64'(operands_equal))
						+ field_differs("result_zero", 64'(want.result_zero), 64'(result_zero))
						+ field_differs("result_odd", 64'(want.result_odd), 64'(result_odd));
					if (errs != 0)
						fail_count = fail_count + 1;
					results_checked = results_checked + 1;
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_results.push_back(field_op_result(action,
					{a_limb3, a_limb2, a_limb1, a_limb0},
					{b_limb3, b_limb2, b_limb1, b_limb0}));
			pending = expected_results.size();
		end
	end

endmodule

// ----- bench/secp256k1_field_add_sub_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secp256k1_field_add_sub_unit_tb
// Drives the field add/sub unit with a directed set of edge operands for every
// action, then with random requests under several sender idle levels, and
// gives the verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module secp256k1_field_add_sub_unit_tb
	import sfas_pkg::*;
();

	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         RANDOM_PER_PHASE = 367;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [WORD_W-1:0] ONE      = 256'd1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        action;
	logic [LIMB_W-1:0] a_limb0, a_limb1, a_limb2, a_limb3;
	logic [LIMB_W-1:0] b_limb0, b_limb1, b_limb2, b_limb3;
	logic              done;
	logic [LIMB_W-1:0] r_limb0, r_limb1, r_limb2, r_limb3;
	logic              a_below_prime;
	logic              operands_equal;
	logic              result_zero;
	logic              result_odd;
	int                fail_count;
	int                pending;
	int                results_checked;

	int sender_idle_pct;
	int requests_sent;
	int directed_count;
	int stall_cycles;

	secp256k1_field_add_sub_unit i_dut (.*);

	secp256k1_field_add_sub_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no request or result accepted for %0d cycles", STALL_LIMIT);
			$display("secp256k1_field_add_sub_unit_tb: FAIL");
			$finish;
		end
	end

	task automatic send_request(input logic [2:0] act, input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		action  <= act;
		a_limb0 <= a[63:0];
		a_limb1 <= a[127:64];
		a_limb2 <= a[191:128];
		a_limb3 <= a[255:192];
		b_limb0 <= b[63:0];
		b_limb1 <= b[127:64];
		b_limb2 <= b[191:128];
		b_limb3 <= b[255:192];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	function automatic logic [LIMB_W-1:0] rand_limb();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_operand(input bit in_field);
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] offset;
		offset = WORD_W'($urandom_range(0, 1000));
		case ($urandom_range(0, 9))
			0: w = WORD_W'($urandom_range(0, 15));
			1: w = PRIME - offset - ONE;
			2: w = PRIME + offset;
			3: w = ALL_ONES - offset;
			4: w = {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
			default: w = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		endcase
		if (in_field && w >= PRIME)
			w = w - PRIME;
		return w;
	endfunction

	initial begin
		logic [WORD_W-1:0] op_a;
		logic [WORD_W-1:0] op_b;
		logic [WORD_W-1:0] nudge;
		bit                in_field;
		int                idle_levels[3];

		idle_levels     = '{0, 86, 31};
		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_RANGE;
		a_limb0         = '0;
		a_limb1         = '0;
		a_limb2         = '0;
		a_limb3         = '0;
		b_limb0         = '0;
		b_limb1         = '0;
		b_limb2         = '0;
		b_limb3         = '0;
		stall_cycles    = 0;
		requests_sent   = 0;
		sender_idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		send_request(ACT_ADD, '0, '0);
		send_request(ACT_ADD, PRIME - ONE, ONE);
		send_request(ACT_ADD, PRIME - ONE, PRIME - ONE);
		send_request(ACT_ADD, ALL_ONES, ALL_ONES);
		send_request(ACT_SUB, '0, '0);
		send_request(ACT_SUB, '0, ONE);
		send_request(ACT_SUB, ALL_ONES, '0);
		send_request(ACT_SUB, PRIME, ALL_ONES);
		send_request(ACT_NEG, '0, ALL_ONES);
		send_request(ACT_NEG, ONE, '0);
		send_request(ACT_NEG, PRIME, PRIME);
		send_request(ACT_NEG, ALL_ONES, '0);
		send_request(ACT_HALF, ONE, ONE);
		send_request(ACT_HALF, ALL_ONES, '0);
		send_request(ACT_HALF, 256'd2, '0);
		send_request(ACT_HALF, PRIME, '0);
		send_request(ACT_REDUCE, PRIME - ONE, '0);
		send_request(ACT_REDUCE, PRIME, PRIME);
		send_request(ACT_REDUCE, ALL_ONES, '0);
		send_request(ACT_RANGE, PRIME - ONE, ALL_ONES);
		send_request(ACT_RANGE, PRIME, '0);
		send_request(ACT_RANGE, ALL_ONES, ALL_ONES);
		send_request(ACT_SPARE_LO, PRIME, ONE);
		send_request(ACT_SPARE_HI, ALL_ONES, '0);
		directed_count = requests_sent;

		foreach (idle_levels[phase]) begin
			sender_idle_pct = idle_levels[phase];
			repeat (RANDOM_PER_PHASE) begin
				in_field = ($urandom_range(0, 3) != 0);
				op_a     = rand_operand(in_field);
				nudge    = WORD_W'($urandom_range(1, 3));
				case ($urandom_range(0, 9))
					0: op_b = op_a;
					1: op_b = op_a + nudge;
					2: op_b = op_a - nudge;
					default: op_b = rand_operand(in_field);
				endcase
				send_request(3'($urandom_range(ACT_ADD, ACT_RANGE)), op_a, op_b);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		repeat (4) @(posedge clk);

		$display("covered %0d requests (%0d directed) at sender idle levels of 0, 86 and 31 pct",
			requests_sent, directed_count);
		$display("%0d results checked against the prediction, %0d failed",
			results_checked, fail_count);
		if (fail_count == 0)
			$display("secp256k1_field_add_sub_unit_tb: PASS");
		else
			$display("secp256k1_field_add_sub_unit_tb: FAIL");
		$finish;
	end

endmodule
